// ----- rtl/core/sqbn_pkg.sv -----
// Package for the square root block: payload word types, sequencer states
// and fixed constants. No dependencies.
`default_nettype none
package sqbn_pkg;

    localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
    localparam logic [31:0] TOL_RESET = 32'd6554;
    localparam int unsigned STEP_MAX  = 127;

    typedef enum logic [0:0] {
        FUNC_BISECT = 1'b0,
        FUNC_NEWTON = 1'b1
    } func_t;

    typedef struct packed {
        logic        func;
        logic [31:0] value;
    } in_t;

    typedef struct packed {
        logic [31:0] root;
        logic [6:0]  step_count;
        logic        converged;
    } out_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [32:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_STEP = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_EVAL = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_UPD  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/square_root_bisect_or_newton.sv -----
// Square root of an unsigned Q16.16 word by bisection or Newton-Raphson.
// Depends on sqbn_pkg and sqbn_div.
//
// One word is taken at a time; in_ready is low until the result has been
// handed to the output register. Each bisection midpoint passes through
// step, 32x32 square and compare; each Newton update passes through
// square, compare, the bit-serial 64-bit divider and update. Operands 0
// and 1.0 under bisection finish without a midpoint. The user must write
// the tolerance register (cfg_we/cfg_wdata) only while the block is idle;
// the block itself does not enforce it.
`default_nettype none
module square_root_bisect_or_newton
    import sqbn_pkg::*;
#(
    parameter int unsigned MAX_ITER = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_t         in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_t             out_data,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata
);

    localparam int unsigned NW = $clog2(MAX_ITER + 1);
    localparam logic [NW-1:0] ITER_LIM = NW'(MAX_ITER);

    state_t      state_reg, state_next;
    logic [31:0] tol_reg;
    logic        func_reg, func_next;
    logic [31:0] val_reg, val_next;
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] x_reg, x_next;
    logic [NW-1:0] n_reg, n_next;
    logic [63:0] sq_reg;
    logic        pos_reg, pos_next;
    out_t        res_reg, res_next;
    out_t        out_reg;
    logic        out_valid_reg, out_valid_next;

    logic [63:0] vq, tq, diff;
    logic        sq_ge, in_tol;
    logic [32:0] mid_sum;
    logic [64:0] up_sum;
    logic [6:0]  steps_out;
    div_req_t    dreq;
    div_rsp_t    drsp;

    sqbn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign vq      = {16'b0, val_reg, 16'b0};
    assign tq      = {16'b0, tol_reg, 16'b0};
    assign sq_ge   = (sq_reg >= vq);
    assign diff    = sq_ge ? (sq_reg - vq) : (vq - sq_reg);
    assign in_tol  = (diff <= tq);
    assign mid_sum = {1'b0, a_reg} + {1'b0, b_reg};
    assign up_sum  = {33'b0, x_reg} + {1'b0, drsp.quotient};
    assign steps_out = (32'(n_reg) > STEP_MAX) ? 7'(STEP_MAX) : 7'(n_reg);

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        val_next       = val_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        x_next         = x_reg;
        n_next         = n_reg;
        pos_next       = pos_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        dreq.start     = 1'b0;
        dreq.dividend  = diff;
        dreq.divisor   = {x_reg, 1'b0};

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next = in_data.func;
                    val_next  = in_data.value;
                    n_next    = '0;
                    a_next    = '0;
                    b_next    = (in_data.value >= ONE_Q16) ? in_data.value : ONE_Q16;
                    x_next    = (in_data.value >= ONE_Q16) ? in_data.value : ONE_Q16;
                    if (in_data.func == FUNC_NEWTON)
                        state_next = ST_MUL;
                    else if (in_data.value == 32'd0 || in_data.value == ONE_Q16)
                    begin
                        // exact endpoint, no midpoint needed
                        res_next.root       = in_data.value;
                        res_next.step_count = '0;
                        res_next.converged  = 1'b1;
                        state_next          = ST_DONE;
                    end
                    else
                        state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (n_reg >= ITER_LIM)
                begin
                    res_next.root       = x_reg;
                    res_next.step_count = steps_out;
                    res_next.converged  = 1'b0;
                    state_next          = ST_DONE;
                end
                else
                begin
                    x_next     = mid_sum[32:1];
                    n_next     = n_reg + NW'(1);
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
                state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (func_reg == FUNC_BISECT)
                begin
                    if (sq_ge)
                        b_next = x_reg;
                    else
                        a_next = x_reg;
                    if (in_tol)
                    begin
                        res_next.root       = x_reg;
                        res_next.step_count = steps_out;
                        res_next.converged  = 1'b1;
                        state_next          = ST_DONE;
                    end
                    else
                        state_next = ST_STEP;
                end
                else
                begin
                    priority if (in_tol)
                    begin
                        res_next.root       = x_reg;
                        res_next.step_count = steps_out;
                        res_next.converged  = 1'b1;
                        state_next          = ST_DONE;
                    end
                    else if (x_reg == 32'd0 || n_reg >= ITER_LIM)
                    begin
                        res_next.root       = x_reg;
                        res_next.step_count = steps_out;
                        res_next.converged  = 1'b0;
                        state_next          = ST_DONE;
                    end
                    else
                    begin
                        pos_next   = sq_ge;
                        dreq.start = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (drsp.done)
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                // floor a decrease at zero, saturate an increase
                if (pos_reg)
                    x_next = (drsp.quotient >= {32'b0, x_reg}) ? 32'd0 :
                             (x_reg - drsp.quotient[31:0]);
                else
                    x_next = (up_sum[64:32] != 33'd0) ? 32'hFFFF_FFFF : up_sum[31:0];
                n_next     = n_reg + NW'(1);
                state_next = ST_MUL;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            tol_reg       <= TOL_RESET;
            n_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            if (cfg_we)
                tol_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        val_reg  <= val_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        x_reg    <= x_next;
        pos_reg  <= pos_next;
        res_reg  <= res_next;
        sq_reg   <= 64'(x_reg) * 64'(x_reg);
        if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
            out_reg <= res_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= ITER_LIM)
        else $error("step counter passed the limit");

    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.busy |-> state_reg == ST_DIV)
        else $error("divider running outside the divide state");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word taken while one is in flight");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !out_valid_reg) |=> out_valid_reg)
        else $error("finished result not moved to output");

endmodule
`default_nettype wire

// ----- rtl/core/sqbn_div.sv -----
// Restoring divider, one quotient bit per cycle: 64-bit dividend over a
// 33-bit divisor. Depends on sqbn_pkg.
`default_nettype none
module sqbn_div
    import sqbn_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [63:0] quo_reg, quo_next;
    logic [33:0] rem_reg, rem_next;
    logic [32:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] rem_sh;
    logic [34:0] rem_sub;

    assign rem_sh  = {rem_reg[32:0], quo_reg[63]};
    assign rem_sub = {1'b0, rem_sh} - {2'b00, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // keep the difference when it does not go negative
            if (!rem_sub[34])
            begin
                rem_next = rem_sub[33:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire
